FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the particle integrator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

FILE: hdl/dpms_pkg.sv
// ----------------------------------------------------------------------------
// dpms_pkg
// Types, constants and helpers for the damped particle midpoint integrator.
// ----------------------------------------------------------------------------
package dpms_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WIDE_W = 68;
  localparam int DIV_W = 49;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int IDX_W = 3;
  localparam int DATA_W = 32;

  localparam logic [30:0] MASS_RESET = 31'd65536;
  localparam logic [30:0] DAMP_RESET = 31'd6554;
  localparam logic [16:0] DT_RESET = 17'd1092;

  localparam logic [IDX_W-1:0] REG_MASS = 3'd0;
  localparam logic [IDX_W-1:0] REG_DAMP = 3'd1;
  localparam logic [IDX_W-1:0] REG_DT = 3'd2;
  localparam logic [IDX_W-1:0] REG_SX = 3'd3;
  localparam logic [IDX_W-1:0] REG_SY = 3'd4;
  localparam logic [IDX_W-1:0] REG_SZ = 3'd5;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_GRAV = 3'd2;
  localparam logic [2:0] OP_HALF = 3'd3;
  localparam logic [2:0] OP_VEL = 3'd4;

  typedef logic signed [WIDE_W-1:0] wide_t;

  function automatic wide_t widen32(input logic [31:0] x);
    widen32 = {{(WIDE_W-32){x[31]}}, x};
  endfunction

  function automatic logic [31:0] sat32(input wide_t x);
    wide_t hi;
    wide_t lo;
    hi = widen32(32'h7fffffff);
    lo = widen32(32'h80000000);
    if (x > hi) begin
      sat32 = 32'h7fffffff;
    end else if (x < lo) begin
      sat32 = 32'h80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  function automatic logic [31:0] clamp_half(input wide_t x, input wide_t half);
    if (x < -half) begin
      clamp_half = 32'(-half);
    end else if (x > half) begin
      clamp_half = half[31:0];
    end else begin
      clamp_half = x[31:0];
    end
  endfunction

endpackage

FILE: hdl/damped_particle_midpoint_step.sv
// ----------------------------------------------------------------------------
// damped_particle_midpoint_step
// Fixed-point midpoint integrator for one particle in a unit box, built on
// one shared multiplier and one bit-serial divider under a sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  opcode_i, force_x/y/z_i
// out       output     out_valid_o/out_stall_i pos_x/y/z_o, mid_x/y/z_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// Force operations and unused opcodes go from idle straight to the output state.
// A velocity update and a half step run each axis in turn through the shared
// multiplier and the bit-serial divider before the output state.
// Reset loads the default registers and zero state; no clearing pass.
// A stalled result holds the sequencer in its output state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module damped_particle_midpoint_step
  import dpms_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              opcode_i,
  input  logic signed [31:0]      force_x_i,
  input  logic signed [31:0]      force_y_i,
  input  logic signed [31:0]      force_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [16:0]      pos_x_o,
  output logic signed [16:0]      pos_y_o,
  output logic signed [16:0]      pos_z_o,
  output logic signed [16:0]      mid_x_o,
  output logic signed [16:0]      mid_y_o,
  output logic signed [16:0]      mid_z_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [DATA_W-1:0]       cfg_data_i
);

  localparam wide_t HALF_W = wide_t'(1) <<< (FRAC_BITS - 1);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_REFL = 13'b0000000000010,
    ST_MPOS = 13'b0000000000100,
    ST_WPOS = 13'b0000000001000,
    ST_MDMP = 13'b0000000010000,
    ST_WNET = 13'b0000000100000,
    ST_MNDT = 13'b0000001000000,
    ST_WDIV = 13'b0000010000000,
    ST_DIV  = 13'b0000100000000,
    ST_WVEL = 13'b0001000000000,
    ST_MADV = 13'b0010000000000,
    ST_WADV = 13'b0100000000000,
    ST_OUT  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic half_q, half_d;
  logic [30:0] mass_q, mass_d;
  logic [30:0] damp_q, damp_d;
  logic [16:0] dt_q, dt_d;
  logic [31:0] pos_q [3];
  logic [31:0] pos_d [3];
  logic [31:0] vel_q [3];
  logic [31:0] vel_d [3];
  logic [31:0] fs_q [3];
  logic [31:0] fs_d [3];
  logic [31:0] midp_q [3];
  logic [31:0] midp_d [3];
  logic [31:0] midv_q [3];
  logic [31:0] midv_d [3];
  logic [31:0] net_q, net_d;
  logic signed [65:0] prod_q, prod_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [30:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic neg_q, neg_d;
  logic out_valid_q, out_valid_d;
  logic [16:0] out_pos_q [3];
  logic [16:0] out_pos_d [3];
  logic [16:0] out_mid_q [3];
  logic [16:0] out_mid_d [3];

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic in_xfer;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MPOS: begin
        mul_a = {vel_q[axis_q][31], vel_q[axis_q]};
        mul_b = {16'd0, dt_q};
      end
      ST_MDMP: begin
        mul_a = {2'b00, damp_q};
        mul_b = half_q ? {vel_q[axis_q][31], vel_q[axis_q]}
                       : {midv_q[axis_q][31], midv_q[axis_q]};
      end
      ST_MNDT: begin
        mul_a = {net_q[31], net_q};
        mul_b = {16'd0, dt_q};
      end
      ST_MADV: begin
        mul_a = {midv_q[axis_q][31], midv_q[axis_q]};
        mul_b = {16'd0, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    wide_t prod_w;
    wide_t p_w;
    wide_t v_w;
    wide_t x_w;
    wide_t q_w;
    logic [30:0] mass_eff;
    logic [31:0] rem_sh;
    logic [31:0] v_cur;
    logic [1:0] cidx;

    state_d = state_q;
    axis_d = axis_q;
    half_d = half_q;
    mass_d = mass_q;
    damp_d = damp_q;
    dt_d = dt_q;
    pos_d = pos_q;
    vel_d = vel_q;
    fs_d = fs_q;
    midp_d = midp_q;
    midv_d = midv_q;
    net_d = net_q;
    prod_d = prod_q;
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    out_valid_d = out_valid_q;
    out_pos_d = out_pos_q;
    out_mid_d = out_mid_q;

    prod_w = {{(WIDE_W-66){prod_q[65]}}, prod_q};
    p_w = widen32(pos_q[axis_q]);
    v_cur = vel_q[axis_q];
    v_w = widen32(v_cur);
    mass_eff = (mass_q == '0) ? 31'd1 : mass_q;
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    q_w = {{(WIDE_W-DIV_W){1'b0}}, quo_q};
    if (neg_q) begin
      q_w = -q_w;
    end
    x_w = '0;
    cidx = 2'd0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MASS: mass_d = cfg_data_i[30:0];
        REG_DAMP: damp_d = cfg_data_i[30:0];
        REG_DT:   dt_d = cfg_data_i[16:0];
        REG_SX, REG_SY, REG_SZ: begin
          cidx = 2'(cfg_index_i - REG_SX);
          pos_d[cidx] = {{15{cfg_data_i[16]}}, cfg_data_i[16:0]};
        end
        default: begin
        end
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          axis_d = 2'd0;
          half_d = (opcode_i == OP_HALF);
          state_d = ST_OUT;
          case (opcode_i)
            OP_CLEAR: begin
              for (int a = 0; a < 3; a++) begin
                fs_d[a] = '0;
              end
            end
            OP_ADD: begin
              fs_d[0] = sat32(widen32(fs_q[0]) + widen32(force_x_i));
              fs_d[1] = sat32(widen32(fs_q[1]) + widen32(force_y_i));
              fs_d[2] = sat32(widen32(fs_q[2]) + widen32(force_z_i));
            end
            OP_GRAV: begin
              fs_d[1] = sat32(widen32(fs_q[1])
                              - (wide_t'(mass_q) <<< 3) - (wide_t'(mass_q) <<< 1));
            end
            OP_HALF: state_d = ST_REFL;
            OP_VEL:  state_d = ST_MDMP;
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_REFL: begin
        if ((p_w <= -HALF_W && v_w < 0) || (p_w >= HALF_W && v_w > 0)) begin
          vel_d[axis_q] = sat32(-v_w);
        end
        state_d = ST_MPOS;
      end
      ST_MPOS: begin
        prod_d = mul_p;
        state_d = ST_WPOS;
      end
      ST_WPOS: begin
        midp_d[axis_q] = clamp_half(p_w + (prod_w >>> (FRAC_BITS + 1)), HALF_W);
        state_d = ST_MDMP;
      end
      ST_MDMP: begin
        prod_d = mul_p;
        state_d = ST_WNET;
      end
      ST_WNET: begin
        net_d = sat32(widen32(fs_q[axis_q]) - (prod_w >>> FRAC_BITS));
        state_d = ST_MNDT;
      end
      ST_MNDT: begin
        prod_d = mul_p;
        state_d = ST_WDIV;
      end
      ST_WDIV: begin
        x_w = half_q ? (prod_w >>> (FRAC_BITS + 1)) : (prod_w >>> FRAC_BITS);
        x_w = x_w <<< FRAC_BITS;
        neg_d = x_w[WIDE_W-1];
        if (x_w[WIDE_W-1]) begin
          x_w = -x_w;
        end
        quo_d = x_w[DIV_W-1:0];
        rem_d = '0;
        cnt_d = CNT_W'(DIV_W);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, mass_eff}) begin
          rem_d = 31'(rem_sh - {1'b0, mass_eff});
          quo_d = {quo_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[30:0];
          quo_d = {quo_q[DIV_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_WVEL;
        end
      end
      ST_WVEL: begin
        if (half_q) begin
          midv_d[axis_q] = sat32(v_w + q_w);
          state_d = ST_MADV;
        end else begin
          vel_d[axis_q] = sat32(v_w + q_w);
          if (axis_q == 2'd2) begin
            state_d = ST_OUT;
          end else begin
            axis_d = axis_q + 2'd1;
            state_d = ST_MDMP;
          end
        end
      end
      ST_MADV: begin
        prod_d = mul_p;
        state_d = ST_WADV;
      end
      ST_WADV: begin
        pos_d[axis_q] = clamp_half(p_w + (prod_w >>> FRAC_BITS), HALF_W);
        if (axis_q == 2'd2) begin
          state_d = ST_OUT;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = ST_REFL;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          for (int a = 0; a < 3; a++) begin
            out_pos_d[a] = pos_q[a][16:0];
            out_mid_d[a] = midp_q[a][16:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q <= '0;
      half_q <= 1'b0;
      mass_q <= MASS_RESET;
      damp_q <= DAMP_RESET;
      dt_q <= DT_RESET;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        pos_q[a] <= '0;
        vel_q[a] <= '0;
        fs_q[a] <= '0;
        midp_q[a] <= '0;
        midv_q[a] <= '0;
      end
    end else begin
      state_q <= state_d;
      axis_q <= axis_d;
      half_q <= half_d;
      mass_q <= mass_d;
      damp_q <= damp_d;
      dt_q <= dt_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
      pos_q <= pos_d;
      vel_q <= vel_d;
      fs_q <= fs_d;
      midp_q <= midp_d;
      midv_q <= midv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    net_q <= net_d;
    prod_q <= prod_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    out_pos_q <= out_pos_d;
    out_mid_q <= out_mid_d;
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o = out_pos_q[0];
  assign pos_y_o = out_pos_q[1];
  assign pos_z_o = out_pos_q[2];
  assign mid_x_o = out_mid_q[0];
  assign mid_y_o = out_mid_q[1];
  assign mid_z_o = out_mid_q[2];

  `ASSERT_NEXT(a_xfer_leaves_idle, clk_i, rst_ni, in_xfer, state_q != ST_IDLE)
  `ASSERT_HOLDS(a_div_count_live, clk_i, rst_ni, state_q != ST_DIV || cnt_q != '0)
  `ASSERT_NEXT(a_pos_clamped, clk_i, rst_ni, state_q == ST_WADV && !cfg_valid_i, widen32(pos_q[axis_q - 2'd1]) <= HALF_W || axis_q == 2'd0)

endmodule
